### hdl/msq_pkg.sv
// ----------------------------------------------------------------------------
// msq_pkg
// Shared constants and types for the matrix square core: store geometry,
// field widths and the control structures passed to the multiply-accumulate.
// ----------------------------------------------------------------------------
`default_nettype none

package msq_pkg;

    // Store geometry
    localparam int MAX_DIM = 64;
    localparam int DIM_W   = $clog2(MAX_DIM);
    localparam int ADDR_W  = 2 * DIM_W;
    localparam int DEPTH   = MAX_DIM * MAX_DIM;
    localparam int CNT_W   = $clog2(MAX_DIM + 1);

    // Field widths fixed by the interface
    localparam int IDX_W  = 6;
    localparam int DATA_W = 32;
    localparam int SIZE_W = 7;

    // Request commands
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_READ  = 1'b1;

    // Control from the sequencer to the accumulator
    typedef struct packed {
        logic start;  // clear the accumulator for a new read
        logic empty;  // the new read has no terms: finish at once
        logic take;   // the finished sum is consumed
    } mac_cmd_t;

    // Tag that travels with each operand pair
    typedef struct packed {
        logic valid;
        logic last;
    } mac_tag_t;

endpackage

`default_nettype wire

### hdl/msq_ram.sv
// ----------------------------------------------------------------------------
// msq_ram
// Synchronous RAM with one write port and two read ports; read data is
// registered.
// ----------------------------------------------------------------------------
`default_nettype none

module msq_ram #(
    parameter int DATA_W = 32,
    parameter int ADDR_W = 12
) (
    input  wire logic              aclk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [DATA_W-1:0] wdata,
    input  wire logic [ADDR_W-1:0] raddr_a,
    input  wire logic [ADDR_W-1:0] raddr_b,
    output logic      [DATA_W-1:0] rdata_a,
    output logic      [DATA_W-1:0] rdata_b
);

    logic [DATA_W-1:0] mem [2**ADDR_W];

    // Write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Read ports, registered
    always_ff @(posedge aclk) begin
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

`default_nettype wire

### hdl/msq_mac.sv
// ----------------------------------------------------------------------------
// msq_mac
// Two-stage multiply-accumulate: a registered 32-bit product, then a
// wrapping accumulator with a done flag that holds until the sum is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module msq_mac (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire msq_pkg::mac_cmd_t             cmd,
    input  wire msq_pkg::mac_tag_t             tag,
    input  wire logic [msq_pkg::DATA_W-1:0]    op_a,
    input  wire logic [msq_pkg::DATA_W-1:0]    op_b,
    output logic      [msq_pkg::DATA_W-1:0]    acc,
    output logic                               done
);

    logic [msq_pkg::DATA_W-1:0] product_reg;
    logic [msq_pkg::DATA_W-1:0] product_next;
    msq_pkg::mac_tag_t          tag_reg;
    logic [msq_pkg::DATA_W-1:0] acc_reg;
    logic [msq_pkg::DATA_W-1:0] acc_next;
    logic                       done_reg;
    logic                       done_next;

    // Multiply, keep the low word (wraps the same for signed operands)
    assign product_next = msq_pkg::DATA_W'(op_a * op_b);

    always_ff @(posedge aclk) begin
        product_reg <= product_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag_reg <= '0;
        end else begin
            tag_reg <= tag;
        end
    end

    // Accumulate, clear on a new read
    always_comb begin
        acc_next = acc_reg;
        if (cmd.start) begin
            acc_next = '0;
        end else if (tag_reg.valid) begin
            acc_next = acc_reg + product_reg;
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg <= acc_next;
    end

    // Flag the finished sum until it is taken
    always_comb begin
        done_next = done_reg;
        if (cmd.start) begin
            done_next = cmd.empty;
        end else if (tag_reg.valid && tag_reg.last) begin
            done_next = 1'b1;
        end else if (cmd.take) begin
            done_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            done_reg <= 1'b0;
        end else begin
            done_reg <= done_next;
        end
    end

    assign acc  = acc_reg;
    assign done = done_reg;

endmodule

`default_nettype wire

### hdl/matrix_square_core.sv
// ----------------------------------------------------------------------------
// matrix_square_core
// Squares a signed 32-bit matrix held in an on-chip store, one element of
// the square per read request.
// ----------------------------------------------------------------------------
// Usage:
//   Input requests arrive on s_valid/s_ready. A write request (s_cmd 0)
//   stores s_value at (s_row, s_col) and gives no result.
//   A read request (s_cmd 1) returns element (s_row, s_col) of the
//   square on m_valid/m_ready: the wrapped sum over k of A[row][k]*A[k][col]
//   for k below min(size, 64).
//   A read walks the store at one term per cycle through the two read ports
//   of the element RAM, n = min(size, 64) terms in all. No new request is
//   taken until that read's sum has been loaded into the output register.
//   The result sits in an output register; the core accepts the next request
//   while it waits. If the receiver stalls and a second read finishes, the
//   second sum is held in the accumulator and the input stays blocked.
//   The size register is written on cfg_valid/cfg_ready while the core is
//   idle. Reset sets size to 64 and empties the output; the element store is
//   not cleared, so an element must be written before it is read.
// ----------------------------------------------------------------------------
`default_nettype none

module matrix_square_core (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    // Request channel
    input  wire logic                                 s_valid,
    output logic                                      s_ready,
    input  wire logic                                 s_cmd,
    input  wire logic        [msq_pkg::IDX_W-1:0]     s_row,
    input  wire logic        [msq_pkg::IDX_W-1:0]     s_col,
    input  wire logic signed [msq_pkg::DATA_W-1:0]    s_value,
    // Result channel
    output logic                                      m_valid,
    input  wire logic                                 m_ready,
    output logic signed      [msq_pkg::DATA_W-1:0]    m_product,
    // Size register write channel
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic        [msq_pkg::SIZE_W-1:0]    cfg_data
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_ISSUE = 2'd1;
    localparam logic [1:0] ST_WAIT  = 2'd2;

    logic [1:0]                   state_reg;
    logic [1:0]                   state_next;
    logic [msq_pkg::SIZE_W-1:0]   size_reg;
    logic [msq_pkg::SIZE_W-1:0]   size_next;
    logic [msq_pkg::DIM_W-1:0]    row_reg;
    logic [msq_pkg::DIM_W-1:0]    row_next;
    logic [msq_pkg::DIM_W-1:0]    col_reg;
    logic [msq_pkg::DIM_W-1:0]    col_next;
    logic [msq_pkg::DIM_W-1:0]    k_reg;
    logic [msq_pkg::DIM_W-1:0]    k_next;
    logic [msq_pkg::CNT_W-1:0]    n_reg;
    logic [msq_pkg::CNT_W-1:0]    n_next;
    logic [msq_pkg::CNT_W-1:0]    n_req;
    msq_pkg::mac_tag_t            tag_reg;
    msq_pkg::mac_tag_t            tag_next;
    logic                         m_valid_reg;
    logic                         m_valid_next;
    logic [msq_pkg::DATA_W-1:0]   m_product_reg;
    logic [msq_pkg::DATA_W-1:0]   m_product_next;

    logic                         req_accept;
    logic                         in_range;
    logic                         issue_last;
    logic                         load_out;
    logic                         ram_we;
    logic [msq_pkg::ADDR_W-1:0]   ram_waddr;
    logic [msq_pkg::ADDR_W-1:0]   ram_raddr_a;
    logic [msq_pkg::ADDR_W-1:0]   ram_raddr_b;
    logic [msq_pkg::DATA_W-1:0]   ram_rdata_a;
    logic [msq_pkg::DATA_W-1:0]   ram_rdata_b;
    msq_pkg::mac_cmd_t            mac_cmd;
    logic [msq_pkg::DATA_W-1:0]   mac_acc;
    logic                         mac_done;

    assign s_ready    = (state_reg == ST_IDLE);
    assign cfg_ready  = (state_reg == ST_IDLE);
    assign req_accept = s_valid && s_ready;

    // Indexes past the store drop a write and read as zero
    assign in_range = (int'(s_row) < msq_pkg::MAX_DIM) && (int'(s_col) < msq_pkg::MAX_DIM);

    // Terms in the sum: size, saturated at the store dimension
    assign n_req = (int'(size_reg) > msq_pkg::MAX_DIM) ? msq_pkg::CNT_W'(msq_pkg::MAX_DIM)
                                                       : msq_pkg::CNT_W'(size_reg);

    assign issue_last = (msq_pkg::CNT_W'(k_reg) + 1'b1) == n_reg;
    assign load_out   = (state_reg == ST_WAIT) && mac_done && (!m_valid_reg || m_ready);

    // Store write on a write request
    assign ram_we    = req_accept && (s_cmd == msq_pkg::CMD_WRITE) && in_range;
    assign ram_waddr = (msq_pkg::ADDR_W'(s_row) << msq_pkg::DIM_W) | msq_pkg::ADDR_W'(s_col);

    // Row operand A[row][k], column operand A[k][col]
    assign ram_raddr_a = {row_reg, k_reg};
    assign ram_raddr_b = {k_reg, col_reg};

    // Sequencer
    always_comb begin
        state_next = state_reg;
        size_next  = size_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        k_next     = k_reg;
        n_next     = n_reg;
        tag_next   = '0;
        mac_cmd    = '0;
        case (state_reg)
            ST_IDLE: begin
                if (cfg_valid) begin
                    size_next = cfg_data;
                end
                if (req_accept && (s_cmd == msq_pkg::CMD_READ)) begin
                    row_next      = msq_pkg::DIM_W'(s_row);
                    col_next      = msq_pkg::DIM_W'(s_col);
                    k_next        = '0;
                    n_next        = n_req;
                    mac_cmd.start = 1'b1;
                    mac_cmd.empty = !in_range || (n_req == '0);
                    state_next    = mac_cmd.empty ? ST_WAIT : ST_ISSUE;
                end
            end
            ST_ISSUE: begin
                tag_next.valid = 1'b1;
                tag_next.last  = issue_last;
                k_next         = k_reg + 1'b1;
                if (issue_last) begin
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT: begin
                if (load_out) begin
                    mac_cmd.take = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output register: load a finished sum, drop it when taken
    always_comb begin
        m_valid_next   = m_valid_reg;
        m_product_next = m_product_reg;
        if (load_out) begin
            m_valid_next   = 1'b1;
            m_product_next = mac_acc;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            size_reg    <= msq_pkg::SIZE_W'(msq_pkg::MAX_DIM);
            tag_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            size_reg    <= size_next;
            tag_reg     <= tag_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        row_reg       <= row_next;
        col_reg       <= col_next;
        k_reg         <= k_next;
        n_reg         <= n_next;
        m_product_reg <= m_product_next;
    end

    msq_ram #(
        .DATA_W (msq_pkg::DATA_W),
        .ADDR_W (msq_pkg::ADDR_W)
    ) u_ram (
        .aclk    (aclk),
        .we      (ram_we),
        .waddr   (ram_waddr),
        .wdata   (s_value),
        .raddr_a (ram_raddr_a),
        .raddr_b (ram_raddr_b),
        .rdata_a (ram_rdata_a),
        .rdata_b (ram_rdata_b)
    );

    msq_mac u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (mac_cmd),
        .tag     (tag_reg),
        .op_a    (ram_rdata_a),
        .op_b    (ram_rdata_b),
        .acc     (mac_acc),
        .done    (mac_done)
    );

    assign m_valid   = m_valid_reg;
    assign m_product = m_product_reg;

`ifndef NO_ASSERTIONS
    // Store is written only between reads
    a_write_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> (state_reg == ST_IDLE))
        else $error("store written during a read");

    // Term index stays below the term count while issuing
    a_k_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ISSUE) |-> (msq_pkg::CNT_W'(k_reg) < n_reg))
        else $error("term index past term count");

    // A sum is never complete while terms are still in flight
    a_done_flush: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ISSUE) |-> !mac_done)
        else $error("accumulator done during issue");

    // A loaded result appears at the output on the next cycle
    a_load_out: assert property (@(posedge aclk) disable iff (!aresetn)
        load_out |=> (m_valid_reg && (state_reg == ST_IDLE)))
        else $error("result load lost");
`endif

endmodule

`default_nettype wire

### test/matrix_square_core_tb.sv
// ----------------------------------------------------------------------------
// matrix_square_core_tb
// Self-checking bench for the matrix square core. A directed opening covers
// extreme element values, the corner indexes, and an empty sum. Random phases
// follow, each at a different matrix size, including size zero and a size
// beyond the store dimension. Every read request only touches elements that
// were written earlier. A local mirror of the element store predicts each
// element of the square. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
`default_nettype none

module matrix_square_core_tb;

    // One request on the input channel
    typedef struct packed {
        logic                       cmd;
        logic [msq_pkg::IDX_W-1:0]  row;
        logic [msq_pkg::IDX_W-1:0]  col;
        logic [msq_pkg::DATA_W-1:0] value;
    } sq_req_t;

    // One predicted element of the square
    typedef struct packed {
        logic [msq_pkg::IDX_W-1:0]  row;
        logic [msq_pkg::IDX_W-1:0]  col;
        logic [msq_pkg::DATA_W-1:0] product;
    } sq_elem_t;

    logic                              aclk      = 1'b0;
    logic                              aresetn   = 1'b0;
    logic                              s_valid   = 1'b0;
    logic                              s_ready;
    logic                              s_cmd     = msq_pkg::CMD_WRITE;
    logic        [msq_pkg::IDX_W-1:0]  s_row     = '0;
    logic        [msq_pkg::IDX_W-1:0]  s_col     = '0;
    logic signed [msq_pkg::DATA_W-1:0] s_value   = '0;
    logic                              m_valid;
    logic                              m_ready   = 1'b0;
    logic signed [msq_pkg::DATA_W-1:0] m_product;
    logic                              cfg_valid = 1'b0;
    logic                              cfg_ready;
    logic        [msq_pkg::SIZE_W-1:0] cfg_data  = '0;

    // Prediction state: mirror of the element store and the active size
    logic [msq_pkg::DATA_W-1:0] elem_mirror [msq_pkg::DEPTH];
    int                         cur_size = msq_pkg::MAX_DIM;

    // Generator state: which elements hold a value, and the size in use
    bit                elem_written [msq_pkg::DEPTH];
    int                gen_size  = msq_pkg::MAX_DIM;
    int                gen_count = 0;
    int                read_points [$];

    sq_req_t  pending_reqs [$];
    sq_elem_t expected_products [$];

    bit s_fire     = 1'b0;
    bit m_fire     = 1'b0;
    bit src_calm   = 1'b0;
    bit snk_calm   = 1'b0;
    int s_gap      = 0;
    int m_stall    = 0;
    int mismatches = 0;

    matrix_square_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_cmd     (s_cmd),
        .s_row     (s_row),
        .s_col     (s_col),
        .s_value   (s_value),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_product (m_product),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #10 aclk = ~aclk;

    // Element (r, c) of the square over the active size, wrapped to 32 bits
    function automatic logic [msq_pkg::DATA_W-1:0] square_elem(input int r, input int c);
        logic [msq_pkg::DATA_W-1:0] acc;
        int                         n;
        int                         k;
        n   = (cur_size > msq_pkg::MAX_DIM) ? msq_pkg::MAX_DIM : cur_size;
        acc = '0;
        for (k = 0; k < n; k++) begin
            acc = acc + elem_mirror[r * msq_pkg::MAX_DIM + k]
                      * elem_mirror[k * msq_pkg::MAX_DIM + c];
        end
        return acc;
    endfunction

    function automatic int draw_gap(input bit calm);
        return calm ? 0 : $urandom_range(0, 14);
    endfunction

    function automatic logic [msq_pkg::DATA_W-1:0] rand_value();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'hFFFF_FFFF;
            3: return 32'h0000_0000;
            default: return $urandom;
        endcase
    endfunction

    // Large sizes reuse a few rows and columns so reads stay affordable
    function automatic int pick_index();
        int hot [4];
        hot = '{0, 21, 42, 63};
        if (gen_size > 16) begin
            return hot[$urandom_range(0, 3)];
        end
        return $urandom_range(0, msq_pkg::MAX_DIM - 1);
    endfunction

    function automatic bit is_idle();
        return pending_reqs.size() == 0 && !s_valid && expected_products.size() == 0;
    endfunction

    // ------------------------------------------------------------------
    // Request driver: sample acceptance and predict at the rising edge
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : sample_requests
        sq_elem_t pred;
        s_fire = aresetn && s_valid && s_ready;
        if (s_fire) begin
            if (s_cmd == msq_pkg::CMD_WRITE) begin
                elem_mirror[int'(s_row) * msq_pkg::MAX_DIM + int'(s_col)] = s_value;
            end else begin
                pred.row          = s_row;
                pred.col          = s_col;
                pred.product      = square_elem(int'(s_row), int'(s_col));
                expected_products = {expected_products, pred};
            end
        end
    end

    // Present the next request at the falling edge
    always @(negedge aclk) begin : drive_requests
        sq_req_t req;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (s_valid && !s_fire) begin
            // hold the request until it is accepted
        end else if (s_gap > 0) begin
            s_valid <= 1'b0;
            s_gap   <= s_gap - 1;
        end else if (pending_reqs.size() != 0) begin
            req      = pending_reqs.pop_front();
            s_cmd   <= req.cmd;
            s_row   <= req.row;
            s_col   <= req.col;
            s_value <= req.value;
            s_valid <= 1'b1;
            s_gap   <= draw_gap(src_calm);
            if ($urandom_range(0, 63) == 0) begin
                src_calm <= !src_calm;
            end
        end else begin
            s_valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Result monitor: compare each product with the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : check_products
        sq_elem_t want;
        m_fire = aresetn && m_valid && m_ready;
        if (m_fire) begin
            if (expected_products.size() == 0) begin
                $display("%0t: unexpected product, expected none, actual %0d",
                         $time, m_product);
                mismatches++;
            end else begin
                want = expected_products.pop_front();
                if (m_product !== want.product) begin
                    $display("%0t: product (%0d,%0d) expected %0d, actual %0d",
                             $time, want.row, want.col, $signed(want.product),
                             m_product);
                    mismatches++;
                end
            end
        end
    end

    // Stall the result channel for a random count after each result
    always @(negedge aclk) begin : pace_results
        int stall;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (m_fire) begin
            stall    = draw_gap(snk_calm);
            m_ready <= (stall == 0);
            m_stall <= (stall > 0) ? stall - 1 : 0;
            if ($urandom_range(0, 31) == 0) begin
                snk_calm <= !snk_calm;
            end
        end else if (m_stall > 0) begin
            m_ready <= 1'b0;
            m_stall <= m_stall - 1;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus generation
    // ------------------------------------------------------------------
    task automatic push_write(input int r, input int c, input logic [msq_pkg::DATA_W-1:0] v);
        sq_req_t req;
        req.cmd      = msq_pkg::CMD_WRITE;
        req.row      = msq_pkg::IDX_W'(r);
        req.col      = msq_pkg::IDX_W'(c);
        req.value    = v;
        pending_reqs = {pending_reqs, req};
        elem_written[r * msq_pkg::MAX_DIM + c] = 1'b1;
        gen_count++;
    endtask

    task automatic push_read(input int r, input int c);
        sq_req_t req;
        req.cmd      = msq_pkg::CMD_READ;
        req.row      = msq_pkg::IDX_W'(r);
        req.col      = msq_pkg::IDX_W'(c);
        req.value    = rand_value();
        pending_reqs = {pending_reqs, req};
        gen_count++;
    endtask

    // Fill in whatever row r and column c still lack, now and then rewriting a row element, then read (r, c)
    task automatic cover_and_read(input int r, input int c);
        int n;
        int k;
        n = (gen_size > msq_pkg::MAX_DIM) ? msq_pkg::MAX_DIM : gen_size;
        for (k = 0; k < n; k++) begin
            if (!elem_written[r * msq_pkg::MAX_DIM + k] || $urandom_range(0, 15) == 0) begin
                push_write(r, k, rand_value());
            end
            if (!elem_written[k * msq_pkg::MAX_DIM + c]) begin
                push_write(k, c, rand_value());
            end
        end
        push_read(r, c);
        read_points = {read_points, r * msq_pkg::MAX_DIM + c};
    endtask

    task automatic run_random(input int budget);
        int first;
        int act;
        int pt;
        first = gen_count;
        read_points.delete();
        while (gen_count - first < budget) begin
            act = $urandom_range(0, 9);
            if (act >= 8) begin
                push_write(pick_index(), pick_index(), rand_value());
            end else if (act >= 5 && read_points.size() != 0) begin
                pt = read_points[$urandom_range(0, read_points.size() - 1)];
                push_read(pt / msq_pkg::MAX_DIM, pt % msq_pkg::MAX_DIM);
            end else begin
                cover_and_read(pick_index(), pick_index());
            end
        end
    endtask

    task automatic wait_idle();
        do @(negedge aclk); while (!is_idle());
    endtask

    // Drain the core, let a trailing write settle, then load the size register
    task automatic set_size(input logic [msq_pkg::SIZE_W-1:0] n);
        wait_idle();
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        cfg_data  <= n;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        cur_size = int'(n);
        gen_size = int'(n);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    initial begin : stimulus
        int k;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: extreme values and corner indexes at size two
        set_size(7'd2);
        push_write(0, 0, 32'h7FFF_FFFF);
        push_write(0, 1, 32'h8000_0000);
        push_write(1, 0, 32'hFFFF_FFFF);
        push_write(1, 1, 32'h0000_0000);
        push_write(63, 0, 32'h0000_0001);
        push_write(63, 1, 32'h8000_0000);
        push_write(0, 63, 32'h8000_0000);
        push_write(1, 63, 32'h7FFF_FFFF);
        push_write(63, 63, 32'hFFFF_FFFF);
        push_read(0, 0);
        push_read(0, 1);
        push_read(1, 0);
        push_read(1, 1);
        push_read(63, 63);
        push_read(0, 63);
        push_read(63, 0);

        // Directed: empty sum at size zero, indexes far beyond the size
        set_size(7'd0);
        push_read(63, 63);
        push_read(12, 40);
        push_read(0, 0);

        // Random phases over several sizes, extremes included
        set_size(7'd3);
        run_random(200);
        set_size(7'd1);
        run_random(150);
        set_size(7'd127);
        run_random(300);
        set_size(7'd0);
        run_random(60);
        set_size(7'd2);
        run_random(150);
        set_size(7'd64);
        run_random(120);
        set_size(7'd9);
        run_random(200);
        set_size(7'd5);
        run_random(170);

        // Drain with a bound, then allow for any late result
        for (k = 0; k < 50000 && !is_idle(); k++) begin
            @(negedge aclk);
        end
        repeat (80) @(posedge aclk);
        if (expected_products.size() != 0) begin
            $display("%0t: %0d products expected, actual none",
                     $time, expected_products.size());
            mismatches++;
        end
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // Hard stop on a hung handshake
    initial begin : watchdog
        #20_000_000;
        $display("FAIL");
        $finish;
    end

endmodule

`default_nettype wire
